/* design/sdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg - shared types and constants of the duplicate filter
// Store depth, element width and the beat record that walks the cell chain.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int SEEN_DEPTH  = 64;
    localparam int VALUE_WIDTH = 32;

    // Beat record handed from one cell to the next
    typedef struct packed {
        logic                   vld;      // slot holds a beat
        logic [VALUE_WIDTH-1:0] value;    // element bit pattern
        logic                   last;     // ends the list
        logic                   found;    // matched a stored entry upstream
        logic                   claimed;  // written into an entry upstream
    } sdf_item_t;

endpackage

/* design/sdf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_in_if / sdf_out_if - valid/ready channels of the duplicate filter
// Input carries list elements, output carries the filtered verdict per beat.
// ----------------------------------------------------------------------------
interface sdf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sdf_pkg::VALUE_WIDTH-1:0] value;
    logic                                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sdf_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sdf_pkg::VALUE_WIDTH-1:0] value_out;
    logic                                  keep;
    logic                                  overflow;
    logic                                  last_out;

    modport source (output valid, output value_out, output keep, output overflow,
                    output last_out, input ready);
    modport sink   (input valid, input value_out, input keep, input overflow,
                    input last_out, output ready);
endinterface

/* design/sdf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_cell - one store entry plus one stage of the beat chain
// Compare the passing beat with the entry, claim the entry if empty, clear on
// the last beat of a list, and register the beat for the next cell.
// ----------------------------------------------------------------------------
module sdf_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  sdf_pkg::sdf_item_t item_in,
    output sdf_pkg::sdf_item_t item_out
);
    import sdf_pkg::*;

    logic                   ent_valid_reg;
    logic                   ent_valid_next;
    logic [VALUE_WIDTH-1:0] ent_value_reg;
    sdf_item_t              item_reg;
    sdf_item_t              item_next;
    logic                   hit;
    logic                   claim;

    always_comb
    begin
        hit   = item_in.vld && ent_valid_reg && (ent_value_reg == item_in.value);
        claim = item_in.vld && !ent_valid_reg && !item_in.found && !item_in.claimed;

        item_next         = item_in;
        item_next.found   = item_in.found | hit;
        item_next.claimed = item_in.claimed | claim;

        // the last beat empties the entry once it has been checked
        ent_valid_next = ent_valid_reg | claim;
        if (item_in.vld && item_in.last)
        begin
            ent_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
            item_reg      <= '0;
        end
        else if (advance)
        begin
            ent_valid_reg <= ent_valid_next;
            item_reg      <= item_next;
        end
    end

    // entry payload: hold until claimed
    always_ff @(posedge clk)
    begin
        if (advance && claim)
        begin
            ent_value_reg <= item_in.value;
        end
    end

    assign item_out = item_reg;

endmodule

/* design/stream_duplicate_filter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_duplicate_filter_unit - first-occurrence filter for unsorted lists
// Systolic chain of compare cells, one store entry per cell.
// ----------------------------------------------------------------------------
// Usage:
//   din  : one list element per beat (value, last). last marks the final
//          element of a list; the store is emptied behind that beat.
//   dout : one result beat per input beat, in order: value_out, keep (first
//          occurrence), overflow (new value but all SEEN_DEPTH entries in use,
//          so it is kept without being recorded) and last_out.
//   Path: a beat is registered in every cell of the chain in turn, and the
//          final cell's stage holds its result beat.
//   Throughput: one beat per cycle while dout is not stalled. Each cell
//          compares the beat passing it with its own entry, so a beat sees
//          every earlier beat's insertion, made in a cell ahead of it.
//   Reset: all entries and chain slots are emptied; the store starts empty.
//   Stall: the whole chain advances together. When dout holds a beat that is
//          not taken, din.ready drops and every cell holds its state.
// ----------------------------------------------------------------------------
module stream_duplicate_filter_unit (
    input logic      clk,
    input logic      rst_n,
    sdf_in_if.sink   din,
    sdf_out_if.source dout
);
    import sdf_pkg::*;

    sdf_item_t chain [0:SEEN_DEPTH];
    logic      advance;

    // advance whenever the output slot is empty or being taken
    assign advance   = !dout.valid || dout.ready;
    assign din.ready = advance;

    // inject a fresh beat, or a bubble when nothing is offered;
    // fields in order: vld, value, last, found, claimed
    assign chain[0] = {din.valid, din.value, din.last, 1'b0, 1'b0};

    for (genvar i = 0; i < SEEN_DEPTH; i++)
    begin : g_cell
        sdf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    // the final cell's stage doubles as the output register
    assign dout.valid     = chain[SEEN_DEPTH].vld;
    assign dout.value_out = chain[SEEN_DEPTH].value;
    assign dout.last_out  = chain[SEEN_DEPTH].last;
    assign dout.keep      = !chain[SEEN_DEPTH].found;
    assign dout.overflow  = !chain[SEEN_DEPTH].found && !chain[SEEN_DEPTH].claimed;

`ifndef NO_ASSERTIONS
    // a dropped copy never reports overflow
    a_drop_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.keep |-> !dout.overflow)
        else $error("duplicate beat flagged as overflow");

    // an accepted beat lands in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        din.valid && din.ready |=> chain[1].vld)
        else $error("accepted beat lost at chain entry");

    // the beat right behind a list end meets an emptied first entry
    a_fresh_list: assert property (@(posedge clk) disable iff (!rst_n)
        chain[1].vld && chain[1].last && advance |=> !chain[1].vld || !chain[1].found)
        else $error("first entry not cleared after list end");
`endif

endmodule
